>>> design/nat_translation_table_core_defines.svh
// Assertion macros shared by the NAT translation table RTL.
`ifndef NAT_TRANSLATION_TABLE_CORE_DEFINES_SVH
`define NAT_TRANSLATION_TABLE_CORE_DEFINES_SVH

// Same-cycle check: whenever ante holds, cons holds too.
`define NTT_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle check: whenever ante holds, cons holds in the next cycle.
`define NTT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

>>> design/ntt_pkg.sv
// Shared types and constants of the NAT translation table.
`timescale 1ns / 1ps

package ntt_pkg;

  // table defaults
  localparam int          ENTRIES_DEF       = 16;
  localparam int          EPHEMERAL_MIN_DEF = 49152;
  localparam logic [15:0] FIRST_PORT_RST    = 16'd49152;
  localparam logic [15:0] PORT_TOP          = 16'hFFFF;

  // slot index carried along the chain (covers up to 1024 slots)
  localparam int IDX_W     = 10;
  localparam int IDX_OUT_W = 4;

  // operation codes
  localparam logic [1:0] OP_OUTBOUND = 2'd0;
  localparam logic [1:0] OP_INBOUND  = 2'd1;
  localparam logic [1:0] OP_OPEN     = 2'd2;

  // status codes
  localparam logic [1:0] ST_NONE   = 2'd0;
  localparam logic [1:0] ST_HIT    = 2'd1;
  localparam logic [1:0] ST_OPENED = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_FINISH
  } state_t;

  // request broadcast to every cell
  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  proto;
    logic [31:0] ia;
    logic [15:0] ip;
    logic [31:0] ra;
    logic [15:0] rp;
    logic [15:0] opt;
  } req_t;

  // running search result handed from cell to cell
  typedef struct packed {
    logic             valid;
    logic             hit;
    logic [IDX_W-1:0] hit_idx;
    logic [31:0]      ia;
    logic [15:0]      ip;
    logic [15:0]      opt;
    logic             free;
    logic [IDX_W-1:0] free_idx;
  } tok_t;

  // slot write / clear command
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] idx;
    logic [15:0]      port;
    logic             clr;
  } wr_t;

endpackage

>>> design/ntt_cell.sv
// One table slot: holds a mapping and folds it into the passing search item.
`timescale 1ns / 1ps

module ntt_cell #(
  parameter int IDX = 0
) (
  input  logic          clk,
  input  logic          rst_n,
  input  ntt_pkg::req_t req,
  input  ntt_pkg::wr_t  wr,
  input  ntt_pkg::tok_t tok_in,
  output ntt_pkg::tok_t tok_out
);

  localparam logic [ntt_pkg::IDX_W-1:0] MY_IDX = ntt_pkg::IDX_W'(IDX);

  logic        valid_r;
  logic [7:0]  proto_r;
  logic [31:0] ia_r;
  logic [15:0] ip_r;
  logic [31:0] ra_r;
  logic [15:0] rp_r;
  logic [15:0] opt_r;

  logic          tok_valid_r;
  ntt_pkg::tok_t tok_r;
  ntt_pkg::tok_t tok_nxt;
  logic          wr_here;
  logic          ob_match;
  logic          ib_match;
  logic          match;

  assign wr_here = wr.en && (wr.idx == MY_IDX);

  // slot valid bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (wr.clr) begin
      valid_r <= 1'b0;
    end else if (wr_here) begin
      valid_r <= 1'b1;
    end
  end

  // slot contents
  always_ff @(posedge clk) begin
    if (wr_here) begin
      proto_r <= req.proto;
      ia_r    <= req.ia;
      ip_r    <= req.ip;
      ra_r    <= req.ra;
      rp_r    <= req.rp;
      opt_r   <= wr.port;
    end
  end

  // compare against the held request
  always_comb begin
    ob_match = valid_r && (proto_r == req.proto) && (ia_r == req.ia) &&
               (ip_r == req.ip) && (ra_r == req.ra) && (rp_r == req.rp);
    ib_match = valid_r && (proto_r == req.proto) && (opt_r == req.opt) &&
               (ra_r == req.ra) && (rp_r == req.rp);
    case (req.op)
      ntt_pkg::OP_OUTBOUND: match = ob_match;
      ntt_pkg::OP_OPEN:     match = ob_match;
      ntt_pkg::OP_INBOUND:  match = ib_match;
      default:              match = 1'b0;
    endcase
  end

  // lowest slot wins: only claim when nothing upstream did
  always_comb begin
    tok_nxt = tok_in;
    if (!tok_in.hit && match) begin
      tok_nxt.hit     = 1'b1;
      tok_nxt.hit_idx = MY_IDX;
      tok_nxt.ia      = ia_r;
      tok_nxt.ip      = ip_r;
      tok_nxt.opt     = opt_r;
    end
    if (!tok_in.free && !valid_r) begin
      tok_nxt.free     = 1'b1;
      tok_nxt.free_idx = MY_IDX;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_valid_r <= 1'b0;
    end else begin
      tok_valid_r <= tok_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    tok_r <= tok_nxt;
  end

  always_comb begin
    tok_out       = tok_r;
    tok_out.valid = tok_valid_r;
  end

endmodule

>>> design/nat_translation_table_core.sv
// Top level of the NAT translation table: request hold, cell chain, finish and output.
//
//  channel | ports                              | transfer
//  input   | in_valid / in_stall, in_* fields   | valid && !stall
//  result  | out_valid / out_stall, out_* fields| valid && !stall
//  config  | cfg_wr_en, cfg_wr_data             | cfg_wr_en
//
// One item at a time: the search item walks the chain one cell per cycle, and
// a new item is accepted only after the last one has finished.
// A finished result waits in the output register; the next item may be
// accepted meanwhile, and its finish waits until that register is free.
// Reset (synchronous, rst_n low) clears all valid bits and loads the port
// counter; a config write clears the slot valid bits and loads the written first port.
`timescale 1ns / 1ps
`include "nat_translation_table_core_defines.svh"

module nat_translation_table_core #(
  parameter int ENTRIES       = ntt_pkg::ENTRIES_DEF,
  parameter int EPHEMERAL_MIN = ntt_pkg::EPHEMERAL_MIN_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_operation,
  input  logic [7:0]  in_protocol,
  input  logic [31:0] in_inside_address,
  input  logic [15:0] in_inside_port,
  input  logic [31:0] in_remote_address,
  input  logic [15:0] in_remote_port,
  input  logic [15:0] in_outside_port,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [3:0]  out_entry_index,
  output logic [31:0] out_mapped_inside_address,
  output logic [15:0] out_mapped_inside_port,
  output logic [15:0] out_mapped_outside_port
);

  localparam logic [15:0] MIN16    = 16'(EPHEMERAL_MIN);
  localparam logic [15:0] RST_PORT =
    (ntt_pkg::FIRST_PORT_RST < MIN16) ? MIN16 : ntt_pkg::FIRST_PORT_RST;

  ntt_pkg::state_t state_r, state_nxt;
  ntt_pkg::req_t   req_r;
  ntt_pkg::tok_t   done_r;
  ntt_pkg::tok_t   tok [ENTRIES+1];
  ntt_pkg::wr_t    wr;

  logic        start_r;
  logic [15:0] next_port_r, next_port_nxt;
  logic        in_accept;
  logic        fire;
  logic        open_new;

  logic        out_valid_r;
  logic [1:0]  status_r, status_nxt;
  logic [ntt_pkg::IDX_W-1:0] idx_r, idx_nxt;
  logic [31:0] ia_r, ia_nxt;
  logic [15:0] ip_r, ip_nxt;
  logic [15:0] opt_r, opt_nxt;

  // control FSM
  always_comb begin
    state_nxt = state_r;
    in_stall  = 1'b1;
    fire      = 1'b0;
    case (state_r)
      ntt_pkg::S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) state_nxt = ntt_pkg::S_SEARCH;
      end
      ntt_pkg::S_SEARCH: begin
        if (tok[ENTRIES].valid) state_nxt = ntt_pkg::S_FINISH;
      end
      ntt_pkg::S_FINISH: begin
        fire = !out_valid_r || !out_stall;
        if (fire) state_nxt = ntt_pkg::S_IDLE;
      end
      default: state_nxt = ntt_pkg::S_IDLE;
    endcase
  end

  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ntt_pkg::S_IDLE;
      start_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      start_r <= in_accept;
    end
  end

  // request hold, broadcast to all cells
  always_ff @(posedge clk) begin
    if (in_accept) begin
      req_r.op    <= in_operation;
      req_r.proto <= in_protocol;
      req_r.ia    <= in_inside_address;
      req_r.ip    <= in_inside_port;
      req_r.ra    <= in_remote_address;
      req_r.rp    <= in_remote_port;
      req_r.opt   <= in_outside_port;
    end
  end

  // search item enters the chain
  always_comb begin
    tok[0]       = '0;
    tok[0].valid = start_r;
  end

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    ntt_cell #(
      .IDX(g)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .req    (req_r),
      .wr     (wr),
      .tok_in (tok[g]),
      .tok_out(tok[g+1])
    );
  end

  // capture the item leaving the last cell
  always_ff @(posedge clk) begin
    if (state_r == ntt_pkg::S_SEARCH && tok[ENTRIES].valid) done_r <= tok[ENTRIES];
  end

  // finish: pick result, open a slot if needed
  always_comb begin
    open_new   = (req_r.op == ntt_pkg::OP_OPEN) && !done_r.hit && done_r.free;
    status_nxt = ntt_pkg::ST_NONE;
    idx_nxt    = '0;
    ia_nxt     = '0;
    ip_nxt     = '0;
    opt_nxt    = '0;
    if (done_r.hit) begin
      status_nxt = ntt_pkg::ST_HIT;
      idx_nxt    = done_r.hit_idx;
      ia_nxt     = done_r.ia;
      ip_nxt     = done_r.ip;
      opt_nxt    = done_r.opt;
    end else if (open_new) begin
      status_nxt = ntt_pkg::ST_OPENED;
      idx_nxt    = done_r.free_idx;
      ia_nxt     = req_r.ia;
      ip_nxt     = req_r.ip;
      opt_nxt    = next_port_r;
    end
    wr.en   = fire && open_new;
    wr.idx  = done_r.free_idx;
    wr.port = next_port_r;
    wr.clr  = cfg_wr_en;
  end

  // outside port counter
  always_comb begin
    next_port_nxt = next_port_r;
    if (cfg_wr_en) begin
      next_port_nxt = (cfg_wr_data < MIN16) ? MIN16 : cfg_wr_data;
    end else if (wr.en) begin
      next_port_nxt = (next_port_r == ntt_pkg::PORT_TOP) ? MIN16 :
                      16'(next_port_r + 16'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      next_port_r <= RST_PORT;
    end else begin
      next_port_r <= next_port_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      status_r <= status_nxt;
      idx_r    <= idx_nxt;
      ia_r     <= ia_nxt;
      ip_r     <= ip_nxt;
      opt_r    <= opt_nxt;
    end
  end

  assign out_valid                 = out_valid_r;
  assign out_status                = status_r;
  assign out_entry_index           = idx_r[ntt_pkg::IDX_OUT_W-1:0];
  assign out_mapped_inside_address = ia_r;
  assign out_mapped_inside_port    = ip_r;
  assign out_mapped_outside_port   = opt_r;

  // checks
  `NTT_ASSERT_NOW(a_chain_in_search, clk, rst_n, tok[ENTRIES].valid,
                  state_r == ntt_pkg::S_SEARCH)
  `NTT_ASSERT_NOW(a_busy_stalls, clk, rst_n, state_r != ntt_pkg::S_IDLE, in_stall)
  `NTT_ASSERT_NEXT(a_open_reports, clk, rst_n, wr.en,
                   out_valid && out_status == ntt_pkg::ST_OPENED)
  `NTT_ASSERT_NEXT(a_accept_starts, clk, rst_n, in_accept, start_r && tok[0].valid)

endmodule
